### design/shape_run_length_delta_decoder_assert.svh
// Assertion macros shared by the run-length delta decoder modules.
// Every module that includes this file has ports named clock and reset.
`ifndef SHAPE_RUN_LENGTH_DELTA_DECODER_ASSERT_SVH
`define SHAPE_RUN_LENGTH_DELTA_DECODER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SRLD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/srld_pkg.sv
// Shared types, constants and helper functions of the run-length delta decoder.
// Used by srld_core, srld_queue and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srld_pkg;

   localparam int WORD_W      = 32;
   localparam int TOTAL_W     = 17;
   localparam int MAX_SAMPLES = 65536;
   localparam int REP_W       = 8;
   localparam int PROD_W      = WORD_W + REP_W + 1;
   localparam int SUM_W       = PROD_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int RSP_DATA_W  = 88;
   localparam int RSP_PAD_W   = RSP_DATA_W - 2 * WORD_W - TOTAL_W;

   localparam logic [0:0] CSR_SAMPLE_TOTAL = 1'b0;
   localparam logic [0:0] CSR_PACKED_TOTAL = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_RUN  = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  first_sample;
      logic signed [WORD_W-1:0]  step;
      logic        [TOTAL_W-1:0] count;
      logic                      last;
      status_type                status;
   } result_type;

   // Results produced by one word; when only one is pushed it is always res_a.
   typedef struct packed {
      logic       push_a;
      logic       push_b;
      result_type res_a;
      result_type res_b;
   } push_type;

   // Saturates a wide signed sum to a Q8.24 word.
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
         r = v[WORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(WORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [TOTAL_W-1:0] clamp_total(input logic [TOTAL_W-1:0] v);
      logic [TOTAL_W-1:0] r;
      if (v > TOTAL_W'(MAX_SAMPLES)) begin
         r = TOTAL_W'(MAX_SAMPLES);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### design/srld_queue.sv
// Result queue of the run-length delta decoder: takes up to two results a cycle,
// hands out one per beat. Depends on srld_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "shape_run_length_delta_decoder_assert.svh"

module srld_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire srld_pkg::push_type push,
   output logic                    room,
   output logic                    head_valid,
   output srld_pkg::result_type    head,
   input  wire logic               pop
);
   import srld_pkg::*;

   result_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   // Room for the two results a single word may cause.
   assign room       = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.push_a) + QPTR_W'(push.push_b);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      count_in  = count_ff + QCNT_W'(push.push_a) + QCNT_W'(push.push_b)
                  - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_a) begin
         entry_ff[wr_ptr_ff] <= push.res_a;
      end
      if (push.push_b) begin
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= push.res_b;
      end
   end

   `SRLD_ASSERT(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH), "result queue overflow")
   `SRLD_ASSERT(a_push_order, !push.push_b || push.push_a, "second result pushed without first")
   `SRLD_ASSERT(a_push_room, !push.push_a || (count_ff <= QCNT_W'(QUEUE_DEPTH - 2)),
                "result pushed without room for two")

endmodule

`default_nettype wire

### design/srld_core.sv
// Decode core: holds the stream state and, while take is high, turns one packed word per
// cycle into up to two segment results. Depends on srld_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "shape_run_length_delta_decoder_assert.svh"

module srld_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear,
   input  wire logic                          take,
   input  wire logic signed [srld_pkg::WORD_W-1:0]  word,
   input  wire logic [srld_pkg::TOTAL_W-1:0]  sample_total,
   input  wire logic [srld_pkg::TOTAL_W-1:0]  packed_total,
   output srld_pkg::push_type                 push
);
   import srld_pkg::*;

   logic signed [WORD_W-1:0] held_ff, held_in;
   logic                     held_valid_ff, held_valid_in;
   logic                     awaiting_ff, awaiting_in;
   logic [TOTAL_W-1:0]       words_seen_ff, words_seen_in;
   logic [TOTAL_W-1:0]       samples_ff, samples_in;
   logic signed [WORD_W-1:0] sum_ff, sum_in;
   logic                     halted_ff, halted_in;

   logic [TOTAL_W-1:0]       st;
   logic [TOTAL_W-1:0]       pt;
   logic                     active;
   logic [TOTAL_W-1:0]       ws_next;
   logic                     last_word;
   logic                     hold_fresh;
   logic                     round_up;
   logic [REP_W:0]           rep_raw;
   logic [REP_W-1:0]         rep_u;
   logic                     rep_bad;
   logic signed [WORD_W-1:0] seg_v1;
   logic signed [WORD_W-1:0] first1;
   logic signed [WORD_W-1:0] first2;
   logic signed [PROD_W-1:0] prod;
   logic signed [WORD_W-1:0] run_sum;
   logic [TOTAL_W-1:0]       se_one;
   logic [TOTAL_W-1:0]       se_two;
   logic [TOTAL_W-1:0]       se_run;
   result_type               err_run;
   result_type               err_total;

   function automatic result_type mk_seg(input logic signed [WORD_W-1:0] first,
                                         input logic signed [WORD_W-1:0] stp,
                                         input logic [TOTAL_W-1:0] cnt,
                                         input logic lst);
      result_type r;
      r.first_sample = first;
      r.step         = stp;
      r.count        = cnt;
      r.last         = lst;
      r.status       = STATUS_OK;
      return r;
   endfunction

   always_comb begin
      st         = clamp_total(sample_total);
      pt         = clamp_total(packed_total);
      active     = !halted_ff && (st != '0) && (words_seen_ff < pt);
      ws_next    = words_seen_ff + TOTAL_W'(1);
      last_word  = (ws_next >= pt);
      hold_fresh = ({1'b0, words_seen_ff} + (TOTAL_W+1)'(2)) < {1'b0, pt};

      // Run count is the integer part truncated toward zero, plus two.
      round_up = word[WORD_W-1] && (|word[WORD_W-REP_W-1:0]);
      rep_raw  = {word[WORD_W-1], word[WORD_W-1:WORD_W-REP_W]}
                 + (REP_W+1)'(round_up) + (REP_W+1)'(2);
      rep_u    = rep_raw[REP_W-1:0];
      rep_bad  = rep_raw[REP_W] || (rep_raw == '0)
                 || (({1'b0, samples_ff} + (TOTAL_W+1)'(rep_u)) > {1'b0, st});

      seg_v1  = (awaiting_ff || held_valid_ff) ? held_ff : word;
      first1  = sat_word(SUM_W'(sum_ff) + SUM_W'(seg_v1));
      first2  = sat_word(SUM_W'(first1) + SUM_W'(word));
      prod    = PROD_W'($signed({1'b0, rep_u})) * PROD_W'(held_ff);
      run_sum = sat_word(SUM_W'(sum_ff) + SUM_W'(prod));
      se_one  = samples_ff + TOTAL_W'(1);
      se_two  = samples_ff + TOTAL_W'(2);
      se_run  = samples_ff + TOTAL_W'(rep_u);

      err_run.first_sample   = '0;
      err_run.step           = '0;
      err_run.count          = '0;
      err_run.last           = 1'b1;
      err_run.status         = STATUS_BAD_RUN;
      err_total              = err_run;
      err_total.status       = STATUS_MISMATCH;

      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      awaiting_in   = awaiting_ff;
      words_seen_in = words_seen_ff;
      samples_in    = samples_ff;
      sum_in        = sum_ff;
      halted_in     = halted_ff;
      push.push_a   = 1'b0;
      push.push_b   = 1'b0;
      push.res_a    = err_total;
      push.res_b    = err_total;

      if (take && active) begin
         words_seen_in = ws_next;
         if (pt == st) begin
            // Uncompressed shape: every word is a one-sample segment.
            push.push_a = 1'b1;
            push.res_a  = mk_seg(word, '0, TOTAL_W'(1), last_word);
            halted_in   = last_word;
         end else if (awaiting_ff) begin
            awaiting_in   = 1'b0;
            held_valid_in = 1'b0;
            push.push_a   = 1'b1;
            if (rep_bad) begin
               push.res_a = err_run;
               halted_in  = 1'b1;
            end else begin
               push.res_a = mk_seg(first1, held_ff, TOTAL_W'(rep_u), se_run >= st);
               sum_in     = run_sum;
               samples_in = se_run;
               if (se_run >= st) begin
                  halted_in = 1'b1;
               end else if (last_word) begin
                  push.push_b = 1'b1;
                  halted_in   = 1'b1;
               end
            end
         end else if (held_valid_ff) begin
            if ((word == held_ff) && !last_word) begin
               awaiting_in = 1'b1;
            end else begin
               // The held word closes as a single sample, then this word starts fresh.
               held_valid_in = 1'b0;
               push.push_a   = 1'b1;
               push.res_a    = mk_seg(first1, held_ff, TOTAL_W'(1), se_one >= st);
               sum_in        = first1;
               samples_in    = se_one;
               if (se_one >= st) begin
                  halted_in = 1'b1;
               end else if (hold_fresh) begin
                  held_in       = word;
                  held_valid_in = 1'b1;
               end else begin
                  push.push_b = 1'b1;
                  push.res_b  = mk_seg(first2, word, TOTAL_W'(1), se_two >= st);
                  sum_in      = first2;
                  samples_in  = se_two;
                  halted_in   = (se_two >= st);
               end
            end
         end else begin
            if (hold_fresh) begin
               held_in       = word;
               held_valid_in = 1'b1;
            end else begin
               push.push_a = 1'b1;
               push.res_a  = mk_seg(first1, word, TOTAL_W'(1), se_one >= st);
               sum_in      = first1;
               samples_in  = se_one;
               if (se_one >= st) begin
                  halted_in = 1'b1;
               end else if (last_word) begin
                  push.push_b = 1'b1;
                  halted_in   = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         awaiting_ff   <= 1'b0;
         words_seen_ff <= '0;
         samples_ff    <= '0;
         sum_ff        <= '0;
         halted_ff     <= 1'b0;
      end else begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         awaiting_ff   <= awaiting_in;
         words_seen_ff <= words_seen_in;
         samples_ff    <= samples_in;
         sum_ff        <= sum_in;
         halted_ff     <= halted_in;
      end
   end

   `SRLD_ASSERT(a_halt_quiet, !halted_ff || !push.push_a, "result produced while halted")
   `SRLD_ASSERT_NEXT(a_halt_sticky, halted_ff && !clear, halted_ff,
                     "halt released without a register write")
   `SRLD_ASSERT(a_samples_bound, samples_ff <= st, "more samples than the sample total")

endmodule

`default_nettype wire

### design/shape_run_length_delta_decoder.sv
// Run-length delta shape decoder, top level: input register, configuration
// registers, decode core and result queue. Depends on srld_pkg, srld_core, srld_queue.
//
// Usage: packed Q8.24 words arrive as beats on the req_ stream. Each word gives
// zero, one or two result beats on the rsp_ stream, each a segment (first
// sample, step, count in tdata; last in tlast; status in tuser). A word is
// registered at acceptance and decoded from that register once the queue has room;
// its results are written into the four-entry result queue and offered from there.
// A second result of the same word is written together with the first, behind it.
// One word is taken per cycle while the queue has room for two results; the
// combinational decode, one 9x32 multiply and saturating adds, sets that rate.
// Configuration is written on the csr_ port (index 0 sample_total, index 1
// packed_total), always ready; any write restarts the shape. Reset sets both
// totals to 1 and clears all stream state; no clearing pass is needed. When the
// receiver stalls, results wait in the queue and req_tready drops once fewer
// than two entries are free and a word waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module shape_run_length_delta_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [srld_pkg::WORD_W-1:0]       req_tdata,   // packed_word
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [srld_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // first_sample, step, count
   output logic                                   rsp_tlast,
   output logic [1:0]                             rsp_tuser,   // status
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [0:0]                        csr_index,
   input  wire logic [srld_pkg::TOTAL_W-1:0]      csr_data
);
   import srld_pkg::*;

   logic signed [WORD_W-1:0] word_ff;
   logic                     in_valid_ff, in_valid_in;
   logic [TOTAL_W-1:0]       sample_total_ff, sample_total_in;
   logic [TOTAL_W-1:0]       packed_total_ff, packed_total_in;
   logic                     csr_write;
   logic                     take;
   logic                     room;
   logic                     head_valid;
   result_type               head;
   push_type                 push;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign take       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || take;

   always_comb begin
      sample_total_in = sample_total_ff;
      packed_total_in = packed_total_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SAMPLE_TOTAL: sample_total_in = csr_data;
            CSR_PACKED_TOTAL: packed_total_in = csr_data;
            default: ;
         endcase
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_total_ff <= TOTAL_W'(1);
         packed_total_ff <= TOTAL_W'(1);
         in_valid_ff     <= 1'b0;
      end else begin
         sample_total_ff <= sample_total_in;
         packed_total_ff <= packed_total_in;
         in_valid_ff     <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         word_ff <= req_tdata;
      end
   end

   srld_core u_core (
      .clock        (clock),
      .reset        (reset),
      .clear        (csr_write),
      .take         (take),
      .word         (word_ff),
      .sample_total (sample_total_ff),
      .packed_total (packed_total_ff),
      .push         (push)
   );

   srld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (head_valid),
      .head       (head),
      .pop        (rsp_tready)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, head.count, head.step, head.first_sample};
   assign rsp_tlast  = head.last;
   assign rsp_tuser  = head.status;

endmodule

`default_nettype wire

### test/shape_run_length_delta_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of shape_run_length_delta_decoder: streams packed words and register
// writes, predicts every segment beat and compares it field by field as it is accepted.
// Depends on srld_pkg and the decoder RTL.

module shape_run_length_delta_decoder_tb;
   import srld_pkg::*;

   localparam longint WORD_MAX     = 64'sd2147483647;
   localparam longint WORD_MIN     = -64'sd2147483648;
   localparam int     ITEM_TARGET  = 1150;
   localparam int     LONG_HOLD    = 300;
   localparam int     DRAIN_CYCLES = 6;

   // Tracks the decoder's configuration and stream state and keeps the segments still owed.
   class shape_scoreboard;
      logic [TOTAL_W-1:0] sample_total;
      logic [TOTAL_W-1:0] packed_total;
      longint held_word;
      bit held_valid;
      bit awaiting_count;
      longint words_seen;
      longint samples_done;
      longint running_sum;
      bit halted;
      result_type expected_segments[$];
      int errors;
      int words_used;
      int segments_checked;
      int bad_runs;
      int mismatches;

      function new();
         sample_total = 1;
         packed_total = 1;
         errors = 0;
         words_used = 0;
         segments_checked = 0;
         bad_runs = 0;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         held_word = 0;
         held_valid = 0;
         awaiting_count = 0;
         words_seen = 0;
         samples_done = 0;
         running_sum = 0;
         halted = 0;
      endfunction

      function void write_reg(logic [0:0] index, logic [TOTAL_W-1:0] value);
         if (index == CSR_SAMPLE_TOTAL) begin
            sample_total = value;
         end else begin
            packed_total = value;
         end
         restart();
      endfunction

      function int pending();
         return expected_segments.size();
      endfunction

      function longint clamp_word(longint v);
         if (v > WORD_MAX) return WORD_MAX;
         if (v < WORD_MIN) return WORD_MIN;
         return v;
      endfunction

      // Integer part of a Q8.24 value, truncated toward zero.
      function longint whole_part(longint v);
         if (v >= 0) return v >> 24;
         return -((-v) >> 24);
      endfunction

      function longint used_total(logic [TOTAL_W-1:0] v);
         return (v > MAX_SAMPLES) ? longint'(MAX_SAMPLES) : longint'(v);
      endfunction

      function void expect_segment(longint first, longint stp, longint cnt, bit last,
                                   status_type status);
         result_type r;
         r.first_sample = first[WORD_W-1:0];
         r.step = stp[WORD_W-1:0];
         r.count = cnt[TOTAL_W-1:0];
         r.last = last;
         r.status = status;
         expected_segments.push_back(r);
      endfunction

      function void add_samples(longint v, longint reps, longint st);
         longint first;
         bit ends;
         first = clamp_word(running_sum + v);
         running_sum = clamp_word(running_sum + reps * v);
         samples_done += reps;
         ends = samples_done >= st;
         expect_segment(first, v, reps, ends, STATUS_OK);
         if (ends) halted = 1;
      endfunction

      // A new word is held while a run could still start at it, else it is one sample.
      function void take_fresh(longint v, longint idx, longint pt, longint st);
         if (idx + 2 < pt) begin
            held_word = v;
            held_valid = 1;
         end else begin
            add_samples(v, 1, st);
         end
      endfunction

      // Returns 1 when the word is decoded and 0 when the block ignores it.
      function bit note_word(logic [WORD_W-1:0] word);
         longint st;
         longint pt;
         longint idx;
         longint v;
         longint reps;
         st = used_total(sample_total);
         pt = used_total(packed_total);
         if (halted || st == 0 || words_seen >= pt) return 0;
         v = longint'($signed(word));
         idx = words_seen;
         words_seen++;
         words_used++;
         if (pt == st) begin
            expect_segment(v, 0, 1, words_seen >= pt, STATUS_OK);
            if (words_seen >= pt) halted = 1;
            return 1;
         end
         if (awaiting_count) begin
            reps = whole_part(v) + 2;
            awaiting_count = 0;
            held_valid = 0;
            if (reps <= 0 || samples_done + reps > st) begin
               expect_segment(0, 0, 0, 1, STATUS_BAD_RUN);
               halted = 1;
               return 1;
            end
            add_samples(held_word, reps, st);
         end else if (held_valid) begin
            if (v == held_word && idx + 1 < pt) begin
               awaiting_count = 1;
            end else begin
               held_valid = 0;
               add_samples(held_word, 1, st);
               if (!halted) take_fresh(v, idx, pt, st);
            end
         end else begin
            take_fresh(v, idx, pt, st);
         end
         if (!halted && words_seen >= pt) begin
            expect_segment(0, 0, 0, 1, STATUS_MISMATCH);
            halted = 1;
         end
         return 1;
      endfunction

      function void check_segment(result_type got);
         result_type want;
         if (expected_segments.size() == 0) begin
            $error("unexpected segment: first_sample %0d step %0d count %0d last %0b status %0d",
                   got.first_sample, got.step, got.count, got.last, got.status);
            errors++;
            return;
         end
         want = expected_segments.pop_front();
         segments_checked++;
         if (want.status == STATUS_BAD_RUN) bad_runs++;
         if (want.status == STATUS_MISMATCH) mismatches++;
         if (got.first_sample !== want.first_sample) begin
            $error("first_sample: expected %0d, got %0d", want.first_sample, got.first_sample);
            errors++;
         end
         if (got.step !== want.step) begin
            $error("step: expected %0d, got %0d", want.step, got.step);
            errors++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [WORD_W-1:0]         req_tdata = '0;     // packed_word
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;          // first_sample, step, count
   logic                      rsp_tlast;
   logic [1:0]                rsp_tuser;          // status
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [0:0]                csr_index = CSR_SAMPLE_TOTAL;
   logic [TOTAL_W-1:0]        csr_data = '0;

   shape_scoreboard sb = new();
   logic [WORD_W-1:0] shape_words[$];
   bit long_hold_due = 1'b0;
   bit rsp_quiet = 1'b0;
   bit send_quiet = 1'b0;
   int shapes_run = 0;

   shape_run_length_delta_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.first_sample = rsp_tdata[WORD_W-1:0];
         got.step = rsp_tdata[2*WORD_W-1:WORD_W];
         got.count = rsp_tdata[2*WORD_W+TOTAL_W-1:2*WORD_W];
         got.last = rsp_tlast;
         got.status = status_type'(rsp_tuser);
         sb.check_segment(got);
      end
   end

   // Result side: a random stall before each beat, quiet stretches, and one long hold-off.
   initial begin : result_sink
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         stall = rsp_quiet ? 0 : $urandom_range(0, 16);
         if (long_hold_due) begin
            stall = LONG_HOLD;
            long_hold_due = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_word(logic [WORD_W-1:0] word);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      void'(sb.note_word(word));
      @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it once its writes are done.
   task automatic write_csr(logic [0:0] index, logic [TOTAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
      @(negedge clock);
   endtask

   // Words that cause no result may still be in flight, so a few cycles pass after draining.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_shape(bit configure, int st, int pt, int pause_at);
      wait_idle();
      if (configure) begin
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_SAMPLE_TOTAL, TOTAL_W'(st));
            write_csr(CSR_PACKED_TOTAL, TOTAL_W'(pt));
         end else begin
            write_csr(CSR_PACKED_TOTAL, TOTAL_W'(pt));
            write_csr(CSR_SAMPLE_TOTAL, TOTAL_W'(st));
         end
         csr_valid <= 1'b0;
      end
      send_quiet = ($urandom_range(0, 3) == 0);
      foreach (shape_words[i]) begin
         if (i == pause_at) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (sb.pending() != 0) @(negedge clock);
         end
         send_word(shape_words[i]);
      end
      shapes_run++;
   endtask

   function automatic logic [WORD_W-1:0] random_delta();
      logic [WORD_W-1:0] v;
      case ($urandom_range(0, 7))
         0, 1: v = $urandom();
         2: v = 32'h7FFF_FFFF;
         3: v = 32'h8000_0000;
         default: v = $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
      endcase
      return v;
   endfunction

   function automatic logic [WORD_W-1:0] distinct_delta(logic [WORD_W-1:0] prev);
      logic [WORD_W-1:0] v;
      v = random_delta();
      if (v == prev) v = ~v;
      return v;
   endfunction

   // Builds a well-formed compressed shape that aims to end exactly at st samples.
   task automatic build_compressed(int st, int pt);
      logic [WORD_W-1:0] v;
      logic [WORD_W-1:0] prev;
      int left_w;
      int room;
      int reps;
      int samples;
      shape_words.delete();
      prev = $urandom();
      samples = 0;
      while (shape_words.size() < pt) begin
         left_w = pt - shape_words.size();
         room = st - samples - (left_w - 3);
         v = distinct_delta(prev);
         if (left_w >= 3 && room >= 2 && (left_w == 3 || $urandom_range(0, 2) != 0)) begin
            if (left_w == 3 && room <= 129) begin
               reps = room;
            end else begin
               reps = $urandom_range(2, (room > 129) ? 129 : room);
            end
            shape_words.push_back(v);
            shape_words.push_back(v);
            prev = {8'(reps - 2), 24'($urandom())};
            shape_words.push_back(prev);
            samples += reps;
         end else begin
            shape_words.push_back(v);
            prev = v;
            samples++;
         end
      end
   endtask

   task automatic build_noise(int n);
      shape_words.delete();
      repeat (n) begin
         if (shape_words.size() > 0 && $urandom_range(0, 2) == 0) begin
            shape_words.push_back(shape_words[$]);
         end else begin
            shape_words.push_back(random_delta());
         end
      end
   endtask

   initial begin : stimulus
      int st;
      int pt;
      int kind;
      int pause_at;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset totals give a one-word passthrough shape; the second word is ignored.
      shape_words = '{32'h7FFF_FFFF, 32'h8000_0000};
      run_shape(0, 1, 1, -1);
      // Longest run of the largest value saturates the sum, then the most negative value.
      shape_words = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000};
      run_shape(1, 131, 5, -1);
      // A run count of zero is a bad run length; the word after it is ignored.
      shape_words = '{32'h0000_0005, 32'h0000_0005, 32'hFE00_0000, 32'h0000_0007};
      run_shape(1, 10, 4, -1);
      // Largest sample total with too few words ends in a count mismatch.
      shape_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0100_0000};
      run_shape(1, 65536, 3, -1);
      // A run that would pass the sample total is a bad run length.
      shape_words = '{32'h0040_0000, 32'h0040_0000, 32'h0800_0000};
      run_shape(1, 4, 5, -1);
      // A negative count word truncates toward zero, giving a run of one.
      shape_words = '{32'h0123_4567, 32'h0123_4567, 32'hFEFF_FFFF, 32'h0000_0100};
      run_shape(1, 2, 4, -1);
      // Largest packed total: the shape ends on the sample total alone.
      shape_words = '{32'hFFF0_0000, 32'hFFF0_0000, 32'h0100_0000};
      run_shape(1, 3, 65536, -1);

      // Long passthrough shape while the result side holds off, so the input stalls.
      build_noise(40);
      long_hold_due = 1'b1;
      run_shape(1, 40, 40, -1);

      while (sb.words_used < ITEM_TARGET) begin
         kind = $urandom_range(0, 19);
         pause_at = -1;
         pt = $urandom_range(1, 30);
         if (kind <= 12) begin
            st = pt + $urandom_range(1, 160);
            build_compressed(st, pt);
            if (kind >= 11) begin
               repeat ($urandom_range(1, 2)) begin
                  shape_words[$urandom_range(0, shape_words.size() - 1)] =
                     $urandom_range(0, 1) ? $urandom() : {8'($urandom_range(128, 255)),
                                                          24'($urandom())};
               end
            end
            if ($urandom_range(0, 3) == 0) pause_at = $urandom_range(1, shape_words.size() - 1);
            if ($urandom_range(0, 3) == 0) shape_words.push_back(random_delta());
         end else if (kind <= 15) begin
            st = pt;
            build_noise(pt + $urandom_range(0, 2));
         end else if (kind <= 17) begin
            st = $urandom_range(1, 40);
            build_noise(pt + 2);
         end else if (kind == 18) begin
            pt = $urandom_range(1, 20);
            st = pt + $urandom_range(0, 40);
            build_compressed(st, pt);
            shape_words.push_back(random_delta());
            shape_words.push_back(random_delta());
            pt = $urandom_range(0, 1) ? 65536 : 131071;
         end else begin
            // Zero totals and totals above the clamp.
            st = $urandom_range(0, 1) ? 0 : $urandom_range(65537, 131071);
            if ($urandom_range(0, 3) == 0) pt = 0;
            build_noise($urandom_range(1, 12));
         end
         run_shape(1, st, pt, pause_at);
      end

      wait_idle();
      $display("Run covered %0d decoded words in %0d shapes, %0d segments checked,",
               sb.words_used, shapes_run, sb.segments_checked);
      $display("including %0d bad-run and %0d count-mismatch endings.",
               sb.bad_runs, sb.mismatches);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("shape_run_length_delta_decoder_tb passed");
      end else begin
         $display("shape_run_length_delta_decoder_tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("shape_run_length_delta_decoder_tb failed");
      $finish;
   end

endmodule
